// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the delay core.
// ----------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("invariant check failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/core/mtfd_pkg.sv -----
// ----------------------------------------------------------------
// Multi-tap feedback delay package
// Sizes, codes, controller/datapath bundles and fixed-point helpers.
// ----------------------------------------------------------------
package mtfd_pkg;

    // Storage sizes
    localparam int BUFFER_DEPTH = 262144;
    localparam int MAX_TAPS     = 128;
    localparam int SAMPLE_WIDTH = 16;

    // Field widths fixed by the interface
    localparam int GAIN_W       = 16;
    localparam int DELAY_W      = 18;
    localparam int TAP_INDEX_W  = 7;
    localparam int TAP_COUNT_W  = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;

    // Derived widths
    localparam int BUF_AW    = $clog2(BUFFER_DEPTH);
    localparam int TAP_IDX_W = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W = TAP_IDX_W + 1;
    localparam int MUL_A_W   = SAMPLE_WIDTH + 1;
    localparam int MUL_B_W   = GAIN_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = PROD_W + TAP_IDX_W;
    localparam int POS_W     = ((BUF_AW > DELAY_W) ? BUF_AW : DELAY_W) + 1;
    localparam int TCMP_W    = (TAP_CNT_W > TAP_COUNT_W) ? TAP_CNT_W : TAP_COUNT_W;

    // Rescaling shifts of the fixed-point products
    localparam int IN_SHIFT  = 12;
    localparam int FB_SHIFT  = 15;
    localparam int TAP_SHIFT = 14;
    localparam int MIX_SHIFT = 15;
    localparam int TERM_W    = PROD_W - IN_SHIFT;

    // Register reset values
    localparam logic [GAIN_W-1:0]      INPUT_GAIN_RST = 16'd4096;
    localparam logic [GAIN_W-1:0]      FEEDBACK_RST   = 16'd0;
    localparam logic [GAIN_W-1:0]      WET_MIX_RST    = 16'd32768;
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST  = 8'd2;

    // Saturation bounds in accumulator width
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_GAIN = 4'd0,
        CFG_FEEDBACK   = 4'd1,
        CFG_WET_MIX    = 4'd2,
        CFG_TAP_COUNT  = 4'd3
    } cfg_index_t;

    // Item kinds
    typedef enum logic {
        OP_SAMPLE    = 1'b0,
        OP_TAP_WRITE = 1'b1
    } op_t;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_INPUT,
        MUL_FEEDBACK,
        MUL_TAP,
        MUL_MIX
    } mul_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 accept;
        logic                 tap_write;
        logic                 mul_en;
        mul_sel_t             mul_sel;
        logic                 term_load;
        logic                 line_write;
        logic                 acc_clear;
        logic                 tap_issue;
        logic [TAP_IDX_W-1:0] tap_addr;
        logic                 sum_load;
        logic                 out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [TAP_CNT_W-1:0] tap_num;
        logic                 pipe_busy;
        logic                 out_free;
    } ctrl_status_t;

    // Add half an LSB of the result, then arithmetic shift right.
    function automatic logic signed [ACC_W-1:0] round_shr(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             s
    );
        logic signed [ACC_W-1:0] bias;
        bias        = '0;
        bias[s - 1] = 1'b1;
        return (v + bias) >>> s;
    endfunction

    // Clip to the signed sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] saturate(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mtfd_ram.sv -----
// ----------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------
module mtfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/mtfd_ctrl.sv -----
// ----------------------------------------------------------------
// Multi-tap delay controller
// Sequences one item at a time: tap writes and the sample steps.
// ----------------------------------------------------------------
`include "assert_macros.svh"

module mtfd_ctrl
    import mtfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         operation,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAP_WRITE,
        ST_MUL_IN,
        ST_MUL_FB,
        ST_LINE_WRITE,
        ST_TAPS,
        ST_DRAIN,
        ST_SUM,
        ST_MIX,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [TAP_IDX_W-1:0] cnt_reg;
    logic                 last_tap;

    // The tap counter has reached the final tap in use.
    assign last_tap = (TAP_CNT_W'(cnt_reg) + TAP_CNT_W'(1)) == status.tap_num;

    // Items are taken only between samples.
    assign in_stall = (state_reg != ST_IDLE);

    // State and tap counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= (operation == OP_TAP_WRITE) ? ST_TAP_WRITE : ST_MUL_IN;
                    end
                end
                ST_TAP_WRITE:  state_reg <= ST_IDLE;
                ST_MUL_IN:     state_reg <= ST_MUL_FB;
                ST_MUL_FB:     state_reg <= ST_LINE_WRITE;
                ST_LINE_WRITE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_TAPS;
                end
                ST_TAPS:
                begin
                    if (last_tap)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + TAP_IDX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!status.pipe_busy)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:        state_reg <= ST_MIX;
                ST_MIX:        state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:       state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath commands per state.
    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_TAP;
        cmd.tap_addr = cnt_reg;
        case (state_reg)
            ST_IDLE:       cmd.accept = in_valid;
            ST_TAP_WRITE:  cmd.tap_write = 1'b1;
            ST_MUL_IN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INPUT;
            end
            ST_MUL_FB:
            begin
                cmd.term_load = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_FEEDBACK;
            end
            ST_LINE_WRITE:
            begin
                cmd.line_write = 1'b1;
                cmd.acc_clear  = 1'b1;
            end
            ST_TAPS:
            begin
                cmd.tap_issue = 1'b1;
                cmd.mul_en    = 1'b1;
            end
            ST_DRAIN:      cmd.mul_en = 1'b1;
            ST_SUM:        cmd.sum_load = 1'b1;
            ST_MIX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MIX;
            end
            ST_OUT:        cmd.out_load = status.out_free;
            default:       cmd.accept = 1'b0;
        endcase
    end

    // An accepted sample starts with the input product.
    `ASSERT_NEXT(a_sample_starts, clk, rst_n, in_valid && !in_stall && operation == OP_SAMPLE, state_reg == ST_MUL_IN)
    // Every issued tap lies within the clamped tap count.
    `ASSERT_IMPLIES(a_issue_in_range, clk, rst_n, cmd.tap_issue, TAP_CNT_W'(cnt_reg) < status.tap_num)

endmodule

// ----- rtl/core/mtfd_datapath.sv -----
// ----------------------------------------------------------------
// Multi-tap delay datapath
// Registers, tap table, delay store, shared multiplier and accumulator.
// ----------------------------------------------------------------
`include "assert_macros.svh"

module mtfd_datapath
    import mtfd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctrl_cmd_t                      cmd,
    output ctrl_status_t                   status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [TAP_INDEX_W-1:0]         tap_index,
    input  logic [DELAY_W-1:0]             tap_delay,
    input  logic [GAIN_W-1:0]              tap_gain,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

    // Configuration registers
    logic [GAIN_W-1:0]      input_gain_reg;
    logic [GAIN_W-1:0]      feedback_reg;
    logic [GAIN_W-1:0]      wet_mix_reg;
    logic [TAP_COUNT_W-1:0] tap_count_reg;

    // Latched item
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [TAP_INDEX_W-1:0]         tidx_reg;
    logic [DELAY_W-1:0]             tdelay_reg;
    logic [GAIN_W-1:0]              tgain_reg;

    // Tap table
    logic [MAX_TAPS-1:0]         tap_valid_reg;
    logic                        tidx_ok;
    logic [DELAY_W+GAIN_W-1:0]   tap_rdata;

    // Delay store and write position
    logic [BUF_AW-1:0]              wp_reg;
    logic                           wrapped_reg;
    logic [BUF_AW-1:0]              line_raddr;
    logic [SAMPLE_WIDTH-1:0]        line_rdata;
    logic signed [SAMPLE_WIDTH-1:0] w_sat;

    // Tap pipeline
    logic              s1_valid_reg;
    logic              s1_known_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    logic [GAIN_W-1:0] gain_s2_reg;
    logic [GAIN_W-1:0] gain_eff;
    logic [POS_W-1:0]  d_ext;
    logic [POS_W-1:0]  d_cl;
    logic [POS_W-1:0]  wp_ext;
    logic [POS_W-1:0]  pos_ext;
    logic              line_filled;

    // Arithmetic
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [MUL_A_W-1:0]      diff;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [TERM_W-1:0]       term_reg;
    logic signed [ACC_W-1:0]        term_next;
    logic signed [ACC_W-1:0]        w_sum;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        mix_sum;
    logic signed [SAMPLE_WIDTH-1:0] last_sum_reg;

    // Output stage
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;

    // Tap count in use
    logic [TCMP_W-1:0] tc_ext;
    logic [TCMP_W-1:0] tc_clamp;

    // Configuration writes; the port never holds a write off.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg <= INPUT_GAIN_RST;
            feedback_reg   <= FEEDBACK_RST;
            wet_mix_reg    <= WET_MIX_RST;
            tap_count_reg  <= TAP_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INPUT_GAIN: input_gain_reg <= cfg_data;
                CFG_FEEDBACK:   feedback_reg   <= cfg_data;
                CFG_WET_MIX:    wet_mix_reg    <= cfg_data;
                CFG_TAP_COUNT:  tap_count_reg  <= cfg_data[TAP_COUNT_W-1:0];
                default:        tap_count_reg  <= tap_count_reg;
            endcase
        end
    end

    // Clamp the tap count to the range the table supports.
    assign tc_ext   = TCMP_W'(tap_count_reg);
    assign tc_clamp = (tc_ext < TCMP_W'(2)) ? TCMP_W'(2) :
                      (tc_ext > TCMP_W'(MAX_TAPS)) ? TCMP_W'(MAX_TAPS) : tc_ext;

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg      <= sample_in;
            tidx_reg   <= tap_index;
            tdelay_reg <= tap_delay;
            tgain_reg  <= tap_gain;
        end
    end

    // Tap table: entries never written read as zero gain.
    assign tidx_ok = int'(tidx_reg) < MAX_TAPS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_valid_reg <= '0;
        end
        else if (cmd.tap_write && tidx_ok)
        begin
            tap_valid_reg[TAP_IDX_W'(tidx_reg)] <= 1'b1;
        end
    end

    mtfd_ram #(
        .WIDTH (DELAY_W + GAIN_W),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (cmd.tap_write && tidx_ok),
        .waddr (TAP_IDX_W'(tidx_reg)),
        .wdata ({tdelay_reg, tgain_reg}),
        .raddr (cmd.tap_addr),
        .rdata (tap_rdata)
    );

    // Stage one: clamp the delay and find the read position behind the writer.
    assign d_ext  = POS_W'(tap_rdata[DELAY_W+GAIN_W-1:GAIN_W]);
    assign wp_ext = POS_W'(wp_reg);
    assign d_cl   = (d_ext > POS_W'(BUFFER_DEPTH - 1)) ? POS_W'(BUFFER_DEPTH - 1) : d_ext;

    always_comb
    begin
        if (wp_ext >= d_cl)
        begin
            pos_ext = wp_ext - d_cl;
        end
        else
        begin
            pos_ext = wp_ext + POS_W'(BUFFER_DEPTH) - d_cl;
        end
    end

    assign line_raddr = pos_ext[BUF_AW-1:0];

    // Before the first wrap, only positions up to the writer hold samples.
    assign line_filled = wrapped_reg || (wp_ext >= d_cl);
    assign gain_eff    = (s1_known_reg && line_filled) ? tap_rdata[GAIN_W-1:0] : '0;

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.tap_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s1_known_reg <= tap_valid_reg[cmd.tap_addr];
        gain_s2_reg  <= gain_eff;
    end

    // Delay store.
    mtfd_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (BUFFER_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.line_write),
        .waddr (wp_reg),
        .wdata (w_sat),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Shared multiplier operands.
    assign diff = MUL_A_W'(last_sum_reg) - MUL_A_W'(x_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_INPUT:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(input_gain_reg);
            end
            MUL_FEEDBACK:
            begin
                mul_a = MUL_A_W'(last_sum_reg);
                mul_b = MUL_B_W'(feedback_reg);
            end
            MUL_MIX:
            begin
                mul_a = diff;
                mul_b = MUL_B_W'(wet_mix_reg);
            end
            default:
            begin
                mul_a = MUL_A_W'($signed(line_rdata));
                mul_b = MUL_B_W'(gain_s2_reg);
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Rescaled input term, written sample and mixed output.
    assign term_next = round_shr(ACC_W'(prod_reg), IN_SHIFT);
    assign w_sum     = ACC_W'(term_reg) + round_shr(ACC_W'(prod_reg), FB_SHIFT);
    assign w_sat     = saturate(w_sum);
    assign mix_sum   = ACC_W'(x_reg) + round_shr(ACC_W'(prod_reg), MIX_SHIFT);

    // Product, input term and tap accumulator.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.term_load)
        begin
            term_reg <= term_next[TERM_W-1:0];
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (s3_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= saturate(mix_sum);
        end
    end

    // Output valid holds while the result is stalled.
    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    // Feedback sum, write position and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sum_reg  <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.sum_load)
            begin
                last_sum_reg <= saturate(round_shr(acc_reg, TAP_SHIFT));
            end
            if (cmd.out_load)
            begin
                if (wp_reg == BUF_AW'(BUFFER_DEPTH - 1))
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + BUF_AW'(1);
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    assign status.tap_num   = TAP_CNT_W'(tc_clamp);
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    // The store is written only while no tap read is in flight.
    `ASSERT_IMPLIES(a_line_write_quiet, clk, rst_n, cmd.line_write, !status.pipe_busy)
    // The tap sum is taken only after the last product has been added.
    `ASSERT_IMPLIES(a_sum_after_drain, clk, rst_n, cmd.sum_load, !status.pipe_busy && !cmd.tap_issue)
    // The writer wraps to the start and marks the store as filled.
    `ASSERT_NEXT(a_wp_wrap, clk, rst_n, cmd.out_load && wp_reg == BUF_AW'(BUFFER_DEPTH - 1), wp_reg == '0 && wrapped_reg)

endmodule

// ----- rtl/core/multi_tap_feedback_delay.sv -----
// ----------------------------------------------------------------
// Multi-tap feedback delay
// Top level: controller and datapath of the feedback delay line.
// ----------------------------------------------------------------
// Items arrive one at a time on a valid/stall channel. A tap write
// (operation 1) loads one tap's delay and gain. An audio sample (operation
// 0) runs the input and feedback products, the store write, a loop over N
// taps (N is tap_count clamped to 2..128), drain, sum, mix and output step
// before the next item is taken. The tap loop reads one tap entry and one
// delay-store word per cycle through the single read port of each memory
// and feeds one shared multiplier. The result sits in an output register,
// and a stalled output holds the block only in the final step of the next
// sample. The delay store needs no clearing pass: a write-position wrap
// flag makes never-written entries read as zero. Configuration writes are
// taken in any cycle but must only be issued while the block is idle.
module multi_tap_feedback_delay
    import mtfd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [TAP_INDEX_W-1:0]         tap_index,
    input  logic [DELAY_W-1:0]             tap_delay,
    input  logic [GAIN_W-1:0]              tap_gain,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Sequencer.
    mtfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage and arithmetic.
    mtfd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .tap_index  (tap_index),
        .tap_delay  (tap_delay),
        .tap_gain   (tap_gain),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

endmodule
